// File: hw/rtl/sbic_pkg.sv
// Package for the stack bytecode integer core: opcodes, status codes,
// register indexes, operation classes and one-hot sequencer states. No dependencies.
package sbic_pkg;

    // Opcodes
    localparam logic [7:0] OP_ICONST_M1 = 8'd2;
    localparam logic [7:0] OP_ICONST_5  = 8'd8;
    localparam logic [7:0] OP_BIPUSH    = 8'd16;
    localparam logic [7:0] OP_SIPUSH    = 8'd17;
    localparam logic [7:0] OP_ILOAD     = 8'd21;
    localparam logic [7:0] OP_ALOAD     = 8'd25;
    localparam logic [7:0] OP_ILOAD_0   = 8'd26;
    localparam logic [7:0] OP_ILOAD_3   = 8'd29;
    localparam logic [7:0] OP_ALOAD_0   = 8'd42;
    localparam logic [7:0] OP_ALOAD_3   = 8'd45;
    localparam logic [7:0] OP_ISTORE    = 8'd54;
    localparam logic [7:0] OP_ASTORE    = 8'd58;
    localparam logic [7:0] OP_ISTORE_0  = 8'd59;
    localparam logic [7:0] OP_ISTORE_3  = 8'd62;
    localparam logic [7:0] OP_ASTORE_0  = 8'd75;
    localparam logic [7:0] OP_ASTORE_3  = 8'd78;
    localparam logic [7:0] OP_POP       = 8'd87;
    localparam logic [7:0] OP_DUP       = 8'd89;
    localparam logic [7:0] OP_IADD      = 8'd96;
    localparam logic [7:0] OP_IDIV      = 8'd108;
    localparam logic [7:0] OP_IINC      = 8'd132;
    localparam logic [7:0] OP_IF_EQ     = 8'd159;
    localparam logic [7:0] OP_IF_NE     = 8'd160;
    localparam logic [7:0] OP_IF_LT     = 8'd161;
    localparam logic [7:0] OP_IF_GE     = 8'd162;
    localparam logic [7:0] OP_IF_GT     = 8'd163;
    localparam logic [7:0] OP_IF_LE     = 8'd164;
    localparam logic [7:0] OP_GOTO      = 8'd167;
    localparam logic [7:0] OP_IRETURN   = 8'd172;
    localparam logic [7:0] OP_RETURN    = 8'd177;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RETVAL   = 3'd1;
    localparam logic [2:0] ST_RETVOID  = 3'd2;
    localparam logic [2:0] ST_UNSUP    = 3'd3;
    localparam logic [2:0] ST_DIVZERO  = 3'd4;
    localparam logic [2:0] ST_STACKERR = 3'd5;
    localparam logic [2:0] ST_BADLOCAL = 3'd6;
    localparam logic [2:0] ST_HALTED   = 3'd7;

    // Register indexes
    localparam logic REG_STACK_LIMIT  = 1'b0;
    localparam logic REG_LOCALS_LIMIT = 1'b1;

    // Decoded operation class
    typedef enum logic [3:0] {
        K_PUSH, K_LOAD, K_STORE, K_POP, K_DUP, K_ALU, K_IINC,
        K_CMP, K_GOTO, K_IRET, K_RET, K_BAD
    } kind_t;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_DFIX  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

endpackage

// File: hw/rtl/stack_bytecode_integer_core_top.sv
// Top level of the stack bytecode integer core: decode, sequencer, stack and
// local memories, a 32-bit adder shared by iadd and iinc, a comparator and a radix-2 divider.
// Depends on sbic_pkg.
//
//  channel   dir  handshake             payload
//  s_*       in   s_valid / s_ready     s_opcode, s_operand_a, s_operand_b
//  m_*       out  m_valid / m_ready     m_next_pc, m_branch_taken, m_result_value,
//                                       m_stack_count, m_status
//  apb       in   psel/penable/pready   paddr, pwdata, prdata
//
// An instruction passes through read, execute, write-back and present, then
// the output handshake (a fault or a halt skips write-back); idiv adds the
// divider steps, one quotient bit a cycle, and a sign fix-up. After reset the
// local store is swept to zero, one entry a cycle, while s_ready stays low.
// s_ready is high only between items; a held result stalls the next item.
module stack_bytecode_integer_core_top #(
    parameter int STACK_DEPTH  = 16,
    parameter int LOCALS_DEPTH = 16,
    parameter int PC_WIDTH     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_operand_a,
    input  logic [7:0]  s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_next_pc,
    output logic        m_branch_taken,
    output logic [31:0] m_result_value,
    output logic [4:0]  m_stack_count,
    output logic [2:0]  m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbic_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int LAW = $clog2(LOCALS_DEPTH);
    localparam int LCW = $clog2(LOCALS_DEPTH + 1);

    // Configuration registers
    logic [4:0] stack_limit_reg, locals_limit_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_limit_reg  <= 5'd16;
            locals_limit_reg <= 5'd16;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_STACK_LIMIT) stack_limit_reg <= pwdata[4:0];
            else                             locals_limit_reg <= pwdata[4:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_STACK_LIMIT) prdata[4:0] = stack_limit_reg;
        else                             prdata[4:0] = locals_limit_reg;
    end

    // Effective capacities
    logic [SPW:0] scap;
    logic [LCW:0] lcap;
    always_comb begin
        if ({{(SPW > 5 ? SPW - 4 : 1){1'b0}}, stack_limit_reg} < (SPW+1)'(STACK_DEPTH))
            scap = (SPW+1)'(stack_limit_reg);
        else
            scap = (SPW+1)'(STACK_DEPTH);
        if ({{(LCW > 5 ? LCW - 4 : 1){1'b0}}, locals_limit_reg} < (LCW+1)'(LOCALS_DEPTH))
            lcap = (LCW+1)'(locals_limit_reg);
        else
            lcap = (LCW+1)'(LOCALS_DEPTH);
    end

    // Memories
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] local_mem [LOCALS_DEPTH];

    state_t          state_reg;
    logic [SPW-1:0]  sp_reg;
    logic [PC_WIDTH-1:0] pc_reg;
    logic            halted_reg;
    logic [LCW-1:0]  clr_reg;
    logic [7:0]      op_reg, a_reg, b_reg;
    kind_t           kind_reg;
    logic [7:0]      idx_reg;
    logic [31:0]     top_reg, sec_reg, loc_reg, res_reg;
    logic            br_reg;
    logic [2:0]      st_reg;
    logic [5:0]      dcnt_reg;
    logic [31:0]     drem_reg, dquo_reg, dden_reg;
    logic            dneg_reg;

    // Decode
    kind_t      kind_d;
    logic [7:0] idx_d;
    always_comb begin
        kind_d = K_BAD;
        idx_d  = s_operand_a;
        if (s_opcode >= OP_ICONST_M1 && s_opcode <= OP_ICONST_5) kind_d = K_PUSH;
        else if (s_opcode == OP_BIPUSH || s_opcode == OP_SIPUSH) kind_d = K_PUSH;
        else if (s_opcode == OP_ILOAD || s_opcode == OP_ALOAD) kind_d = K_LOAD;
        else if (s_opcode >= OP_ILOAD_0 && s_opcode <= OP_ILOAD_3) begin
            kind_d = K_LOAD; idx_d = s_opcode - OP_ILOAD_0;
        end else if (s_opcode >= OP_ALOAD_0 && s_opcode <= OP_ALOAD_3) begin
            kind_d = K_LOAD; idx_d = s_opcode - OP_ALOAD_0;
        end else if (s_opcode == OP_ISTORE || s_opcode == OP_ASTORE) kind_d = K_STORE;
        else if (s_opcode >= OP_ISTORE_0 && s_opcode <= OP_ISTORE_3) begin
            kind_d = K_STORE; idx_d = s_opcode - OP_ISTORE_0;
        end else if (s_opcode >= OP_ASTORE_0 && s_opcode <= OP_ASTORE_3) begin
            kind_d = K_STORE; idx_d = s_opcode - OP_ASTORE_0;
        end else if (s_opcode == OP_POP) kind_d = K_POP;
        else if (s_opcode == OP_DUP) kind_d = K_DUP;
        else if (s_opcode == OP_IADD || s_opcode == OP_IDIV) kind_d = K_ALU;
        else if (s_opcode == OP_IINC) kind_d = K_IINC;
        else if (s_opcode >= OP_IF_EQ && s_opcode <= OP_IF_LE) kind_d = K_CMP;
        else if (s_opcode == OP_GOTO) kind_d = K_GOTO;
        else if (s_opcode == OP_IRETURN) kind_d = K_IRET;
        else if (s_opcode == OP_RETURN) kind_d = K_RET;
    end

    // Stack and local reads, registered
    logic [SAW-1:0] sp_m1, sp_m2;
    assign sp_m1 = SAW'(sp_reg - SPW'(1));
    assign sp_m2 = SAW'(sp_reg - SPW'(2));
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            top_reg <= stack_mem[sp_m1];
            sec_reg <= stack_mem[sp_m2];
            loc_reg <= local_mem[LAW'(idx_reg)];
        end
    end

    // Fault checks
    logic idx_bad, full, lt1, lt2;
    assign idx_bad = {{(LCW > 8 ? LCW - 8 : 1){1'b0}}, idx_reg} >= (LCW+1)'(lcap);
    assign full    = (SPW+1)'(sp_reg) >= scap;
    assign lt1     = sp_reg == '0;
    assign lt2     = sp_reg < SPW'(2);

    logic [2:0] fault;
    always_comb begin
        fault = ST_OK;
        case (kind_reg)
            K_PUSH:  if (full) fault = ST_STACKERR;
            K_LOAD:  if (idx_bad) fault = ST_BADLOCAL; else if (full) fault = ST_STACKERR;
            K_STORE: if (idx_bad) fault = ST_BADLOCAL; else if (lt1) fault = ST_STACKERR;
            K_POP:   if (lt1) fault = ST_STACKERR;
            K_DUP:   if (lt1 || full) fault = ST_STACKERR;
            K_ALU:   if (lt2) fault = ST_STACKERR;
                     else if (op_reg == OP_IDIV && top_reg == '0) fault = ST_DIVZERO;
            K_IINC:  if (idx_bad) fault = ST_BADLOCAL;
            K_CMP:   if (lt2) fault = ST_STACKERR;
            K_IRET:  if (lt1) fault = ST_STACKERR;
            K_GOTO, K_RET: fault = ST_OK;
            default: fault = ST_UNSUP;
        endcase
    end

    // Shared adder: operand select
    logic [31:0] add_a, add_b, add_s;
    logic [32:0] sub_w;
    logic [31:0] imm16;
    assign imm16 = {{16{a_reg[7]}}, a_reg, b_reg};
    always_comb begin
        add_a = sec_reg;
        add_b = top_reg;
        if (kind_reg == K_IINC) begin
            add_a = loc_reg;
            add_b = {{24{b_reg[7]}}, b_reg};
        end
    end
    assign add_s = add_a + add_b;
    assign sub_w = {1'b0, sec_reg ^ 32'h8000_0000} - {1'b0, top_reg ^ 32'h8000_0000};

    logic eq_w, lt_w, take;
    assign eq_w = sec_reg == top_reg;
    assign lt_w = sub_w[32];
    always_comb begin
        case (op_reg)
            OP_IF_EQ: take = eq_w;
            OP_IF_NE: take = !eq_w;
            OP_IF_LT: take = lt_w;
            OP_IF_GE: take = !lt_w;
            OP_IF_GT: take = !lt_w && !eq_w;
            OP_IF_LE: take = lt_w || eq_w;
            default:  take = 1'b0;
        endcase
    end

    logic [31:0] push_val;
    always_comb begin
        if (op_reg == OP_BIPUSH)      push_val = {{24{a_reg[7]}}, a_reg};
        else if (op_reg == OP_SIPUSH) push_val = imm16;
        else                          push_val = 32'(op_reg) - 32'd3;
    end

    logic [PC_WIDTH-1:0] len;
    always_comb begin
        case (kind_reg)
            K_PUSH:  len = (op_reg == OP_BIPUSH) ? PC_WIDTH'(2) :
                           (op_reg == OP_SIPUSH) ? PC_WIDTH'(3) : PC_WIDTH'(1);
            K_LOAD, K_STORE: len = (op_reg == OP_ILOAD || op_reg == OP_ALOAD ||
                                    op_reg == OP_ISTORE || op_reg == OP_ASTORE)
                                   ? PC_WIDTH'(2) : PC_WIDTH'(1);
            K_IINC, K_CMP, K_GOTO: len = PC_WIDTH'(3);
            default: len = PC_WIDTH'(1);
        endcase
    end

    // Divider step
    logic [32:0] dtry;
    assign dtry = {drem_reg, dquo_reg[31]} - {1'b0, dden_reg};

    logic [31:0] top_now;
    assign top_now = (sp_reg == '0) ? 32'd0 : stack_mem[sp_m1];

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            sp_reg     <= '0;
            pc_reg     <= '0;
            halted_reg <= 1'b0;
            clr_reg    <= '0;
            m_valid    <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (clr_reg != LCW'(LOCALS_DEPTH)) begin
                        // sweep locals to zero after reset
                        local_mem[LAW'(clr_reg)] <= '0;
                        clr_reg <= clr_reg + LCW'(1);
                    end else if (s_valid) begin
                        op_reg   <= s_opcode;
                        a_reg    <= s_operand_a;
                        b_reg    <= s_operand_b;
                        kind_reg <= kind_d;
                        idx_reg  <= idx_d;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC: begin
                    br_reg <= 1'b0;
                    st_reg <= ST_OK;
                    if (halted_reg) begin
                        st_reg  <= ST_HALTED;
                        res_reg <= top_now;
                        state_reg <= S_OUT;
                    end else if (fault != ST_OK) begin
                        st_reg  <= fault;
                        res_reg <= top_now;
                        halted_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (op_reg == OP_IDIV) begin
                        // magnitudes into the divider
                        dden_reg <= top_reg[31] ? -top_reg : top_reg;
                        dquo_reg <= sec_reg[31] ? -sec_reg : sec_reg;
                        drem_reg <= '0;
                        dneg_reg <= top_reg[31] ^ sec_reg[31];
                        dcnt_reg <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        case (kind_reg)
                            K_PUSH: res_reg <= push_val;
                            K_LOAD: res_reg <= loc_reg;
                            K_DUP:  res_reg <= top_reg;
                            K_ALU:  res_reg <= add_s;
                            K_IINC: res_reg <= add_s;
                            K_STORE: res_reg <= top_reg;
                            K_IRET: res_reg <= top_reg;
                            default: res_reg <= top_reg;
                        endcase
                        if (kind_reg == K_CMP) br_reg <= take;
                        if (kind_reg == K_GOTO) br_reg <= 1'b1;
                        if (kind_reg == K_IRET) st_reg <= ST_RETVAL;
                        if (kind_reg == K_RET) st_reg <= ST_RETVOID;
                        state_reg <= S_WRITE;
                    end
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    if (!dtry[32]) drem_reg <= dtry[31:0];
                    else           drem_reg <= {drem_reg[30:0], dquo_reg[31]};
                    dquo_reg <= {dquo_reg[30:0], !dtry[32]};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd31) state_reg <= S_DFIX;
                end
                S_DFIX: begin
                    res_reg <= dneg_reg ? -dquo_reg : dquo_reg;
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    // commit stack, locals and pc
                    case (kind_reg)
                        K_PUSH, K_LOAD, K_DUP: begin
                            stack_mem[SAW'(sp_reg)] <= res_reg;
                            sp_reg <= sp_reg + SPW'(1);
                        end
                        K_STORE: begin
                            local_mem[LAW'(idx_reg)] <= res_reg;
                            sp_reg <= sp_reg - SPW'(1);
                        end
                        K_POP, K_IRET: sp_reg <= sp_reg - SPW'(1);
                        K_ALU: begin
                            stack_mem[sp_m2] <= res_reg;
                            sp_reg <= sp_reg - SPW'(1);
                        end
                        K_IINC: local_mem[LAW'(idx_reg)] <= res_reg;
                        K_CMP: sp_reg <= sp_reg - SPW'(2);
                        default: ;
                    endcase
                    if (br_reg) pc_reg <= pc_reg + PC_WIDTH'(imm16);
                    else        pc_reg <= pc_reg + len;
                    if (st_reg == ST_RETVAL || st_reg == ST_RETVOID) halted_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid) begin
                        if (st_reg == ST_OK || st_reg == ST_RETVOID) res_reg <= top_now;
                        m_valid <= 1'b1;
                    end else if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE) && (clr_reg == LCW'(LOCALS_DEPTH));
    assign m_next_pc      = 16'(pc_reg);
    assign m_branch_taken = br_reg;
    assign m_result_value = res_reg;
    assign m_stack_count  = 5'(sp_reg);
    assign m_status       = st_reg;

endmodule
